>>> hw/rtl/sequential_list_engine_unit_assert.svh
// Assertion macros used by the list engine checker.
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication under reset.
`define SLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// Next-cycle implication under reset.
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

>>> hw/rtl/sle_pkg.sv
// Package: widths, sizes and operation codes of the list engine.
`default_nettype none

package sle_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int FUNC_W = 3;
    localparam int POS_W  = 4;
    localparam int DATA_W = 8;

    localparam logic [FUNC_W-1:0] OP_READ    = 3'd0;
    localparam logic [FUNC_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [FUNC_W-1:0] OP_APPEND  = 3'd2;
    localparam logic [FUNC_W-1:0] OP_REMOVE  = 3'd3;
    localparam logic [FUNC_W-1:0] OP_REVERSE = 3'd4;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/sle_if.sv
// Interfaces: request and response channels of the list engine.
`default_nettype none

interface sle_req_if;
    import sle_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] data_in;

    modport source (output valid, output func, output position, output data_in,
                    input ready);
    modport sink   (input valid, input func, input position, input data_in,
                    output ready);
endinterface

interface sle_rsp_if;
    import sle_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic              status;
    logic [CNT_W-1:0]  count;

    modport source (output valid, output data_out, output status, output count,
                    input ready);
    modport sink   (input valid, input data_out, input status, input count,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sequential_list_engine_unit.sv
// Top level: sequential list engine, an ordered byte list in a two-port store.
`default_nettype none

// The engine keeps an ordered list of up to 16 bytes in a small store with one
// read port and one write port, plus an entry count. Each request beat asks for
// one operation (read, insert at a position, append, remove at a position,
// reverse) and yields exactly one response beat with the byte read, a status
// (0 done, 1 error) and the count after the operation. Out-of-range positions,
// insert or append into a full list, and unknown function codes report an
// error and leave the list untouched. One request is worked at a time: req
// ready is high only while the sequencer is idle, and it stays high while a
// finished response still sits in the output register. The time from accept
// to a loaded response is set by the store's single read and write port:
// read and errors go straight to the response, append writes one entry,
// insert at p moves entries count-1 down to p up by one and then writes the
// new byte, remove at p moves the entries above it down by one (nothing for
// the last entry), reverse swaps pairs from both ends, one swap at a time. A
// response meeting an occupied output register waits until the sink frees it.
// The store itself has no reset and no clearing pass: only entries below the
// count are ever read, and each of those has been written.
module sequential_list_engine_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sle_req_if.sink    req,
    sle_rsp_if.source  rsp
);
    import sle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_PUT,
        S_REV_A,
        S_REV_B,
        S_REV_C,
        S_REV_END,
        S_RESP
    } state_t;

    // List store, one read and one write per cycle, registered read data.
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    // Sequencer registers. rd_ptr/end_ptr double as lo/hi during reverse,
    // wr_ptr holds the pending hi write, put_data the saved lo byte.
    state_t            state_reg,     state_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [IDX_W-1:0]  rd_ptr_reg,    rd_ptr_next;
    logic [IDX_W-1:0]  end_ptr_reg,   end_ptr_next;
    logic [IDX_W-1:0]  wr_ptr_reg,    wr_ptr_next;
    logic              pend_reg,      pend_next;
    logic              more_reg,      more_next;
    logic              up_reg,        up_next;
    logic [IDX_W-1:0]  put_addr_reg,  put_addr_next;
    logic [DATA_W-1:0] put_data_reg,  put_data_next;
    logic              stat_reg,      stat_next;
    logic              take_rd_reg,   take_rd_next;

    // Output register.
    logic              ovalid_reg,    ovalid_next;
    logic [DATA_W-1:0] odata_reg,     odata_next;
    logic              ostat_reg,     ostat_next;
    logic [CNT_W-1:0]  ocount_reg,    ocount_next;

    logic              accept;
    logic              pos_ok;
    logic              full;
    logic [CNT_W-1:0]  pos_ext;

    assign req.ready    = (state_reg == S_IDLE);
    assign accept       = req.valid && req.ready;
    assign pos_ext      = CNT_W'(req.position);
    assign pos_ok       = (pos_ext < count_reg);
    assign full         = (count_reg == CNT_W'(DEPTH));

    assign rsp.valid    = ovalid_reg;
    assign rsp.data_out = odata_reg;
    assign rsp.status   = ostat_reg;
    assign rsp.count    = ocount_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        end_ptr_next  = end_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        pend_next     = pend_reg;
        more_next     = more_reg;
        up_next       = up_reg;
        put_addr_next = put_addr_reg;
        put_data_next = put_data_reg;
        stat_next     = stat_reg;
        take_rd_next  = take_rd_reg;
        ovalid_next   = ovalid_reg;
        odata_next    = odata_reg;
        ostat_next    = ostat_reg;
        ocount_next   = ocount_reg;

        mem_re    = 1'b0;
        mem_raddr = rd_ptr_reg;
        mem_we    = 1'b0;
        mem_waddr = wr_ptr_reg;
        mem_wdata = rdata_reg;

        // Drop the response beat once the sink takes it.
        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    stat_next    = ST_OK;
                    take_rd_next = 1'b0;
                    pend_next    = 1'b0;
                    state_next   = S_RESP;
                    case (req.func)
                        OP_READ:
                        begin
                            if (pos_ok)
                            begin
                                mem_re       = 1'b1;
                                mem_raddr    = IDX_W'(req.position);
                                take_rd_next = 1'b1;
                            end
                            else
                            begin
                                stat_next = ST_ERR;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (!pos_ok || full)
                            begin
                                stat_next = ST_ERR;
                            end
                            else
                            begin
                                // Shift entries count-1 down to position up by one.
                                rd_ptr_next   = IDX_W'(count_reg - CNT_W'(1));
                                end_ptr_next  = IDX_W'(req.position);
                                up_next       = 1'b1;
                                more_next     = 1'b1;
                                put_addr_next = IDX_W'(req.position);
                                put_data_next = req.data_in;
                                count_next    = count_reg + CNT_W'(1);
                                state_next    = S_MOVE;
                            end
                        end
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                stat_next = ST_ERR;
                            end
                            else
                            begin
                                put_addr_next = IDX_W'(count_reg);
                                put_data_next = req.data_in;
                                count_next    = count_reg + CNT_W'(1);
                                state_next    = S_PUT;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!pos_ok)
                            begin
                                stat_next = ST_ERR;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                // Removing the last entry moves nothing.
                                if (pos_ext + CNT_W'(1) != count_reg)
                                begin
                                    rd_ptr_next  = IDX_W'(pos_ext + CNT_W'(1));
                                    end_ptr_next = IDX_W'(count_reg - CNT_W'(1));
                                    up_next      = 1'b0;
                                    more_next    = 1'b1;
                                    state_next   = S_MOVE;
                                end
                            end
                        end
                        OP_REVERSE:
                        begin
                            if (count_reg >= CNT_W'(2))
                            begin
                                rd_ptr_next  = '0;
                                end_ptr_next = IDX_W'(count_reg - CNT_W'(1));
                                state_next   = S_REV_A;
                            end
                        end
                        default:
                        begin
                            stat_next = ST_ERR;
                        end
                    endcase
                end
            end

            S_MOVE:
            begin
                // Write back the beat read last cycle, issue the next read.
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                if (more_reg)
                begin
                    mem_re      = 1'b1;
                    pend_next   = 1'b1;
                    wr_ptr_next = up_reg ? rd_ptr_reg + IDX_W'(1)
                                         : rd_ptr_reg - IDX_W'(1);
                    if (rd_ptr_reg == end_ptr_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        rd_ptr_next = up_reg ? rd_ptr_reg - IDX_W'(1)
                                             : rd_ptr_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = up_reg ? S_PUT : S_RESP;
                end
            end

            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = put_addr_reg;
                mem_wdata  = put_data_reg;
                state_next = S_RESP;
            end

            S_REV_A:
            begin
                // Read lo; finish the previous swap's hi write.
                mem_re    = 1'b1;
                mem_raddr = rd_ptr_reg;
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_ptr_reg;
                    mem_wdata = put_data_reg;
                end
                pend_next  = 1'b0;
                state_next = S_REV_B;
            end

            S_REV_B:
            begin
                mem_re        = 1'b1;
                mem_raddr     = end_ptr_reg;
                put_data_next = rdata_reg;
                state_next    = S_REV_C;
            end

            S_REV_C:
            begin
                mem_we       = 1'b1;
                mem_waddr    = rd_ptr_reg;
                mem_wdata    = rdata_reg;
                wr_ptr_next  = end_ptr_reg;
                pend_next    = 1'b1;
                rd_ptr_next  = rd_ptr_reg + IDX_W'(1);
                end_ptr_next = end_ptr_reg - IDX_W'(1);
                if (CNT_W'(rd_ptr_reg) + CNT_W'(2) < CNT_W'(end_ptr_reg))
                begin
                    state_next = S_REV_A;
                end
                else
                begin
                    state_next = S_REV_END;
                end
            end

            S_REV_END:
            begin
                mem_we     = 1'b1;
                mem_waddr  = wr_ptr_reg;
                mem_wdata  = put_data_reg;
                pend_next  = 1'b0;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                // Hold until the output register is free.
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = take_rd_reg ? rdata_reg : '0;
                    ostat_next  = stat_reg;
                    ocount_next = count_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            more_reg     <= 1'b0;
            up_reg       <= 1'b0;
            ovalid_reg   <= 1'b0;
            rd_ptr_reg   <= '0;
            end_ptr_reg  <= '0;
            wr_ptr_reg   <= '0;
            put_addr_reg <= '0;
            put_data_reg <= '0;
            stat_reg     <= ST_OK;
            take_rd_reg  <= 1'b0;
            odata_reg    <= '0;
            ostat_reg    <= ST_OK;
            ocount_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            more_reg     <= more_next;
            up_reg       <= up_next;
            ovalid_reg   <= ovalid_next;
            rd_ptr_reg   <= rd_ptr_next;
            end_ptr_reg  <= end_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            put_addr_reg <= put_addr_next;
            put_data_reg <= put_data_next;
            stat_reg     <= stat_next;
            take_rd_reg  <= take_rd_next;
            odata_reg    <= odata_next;
            ostat_reg    <= ostat_next;
            ocount_reg   <= ocount_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sle_checker.sv
// Checker: port-level properties of the list engine, bound to the top level.
`default_nettype none

`include "sequential_list_engine_unit_assert.svh"

module sle_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       req_valid,
    input wire logic                       req_ready,
    input wire logic                       rsp_valid,
    input wire logic                       rsp_ready,
    input wire logic [sle_pkg::DATA_W-1:0] rsp_data_out,
    input wire logic                       rsp_status,
    input wire logic [sle_pkg::CNT_W-1:0]  rsp_count
);
    import sle_pkg::*;

    // A response beat stays up until taken.
    `SLE_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // One request at a time: no accept right after an accept.
    `SLE_ASSERT_NEXT(a_one_busy, clk, rst_n, req_valid && req_ready, !req_ready)

    // Count never exceeds the store depth.
    `SLE_ASSERT_NOW(a_count_max, clk, rst_n, rsp_valid, rsp_count <= CNT_W'(DEPTH))

    // Only a successful read carries a byte; errors always return zero.
    `SLE_ASSERT_NOW(a_err_zero, clk, rst_n, rsp_valid && (rsp_status == ST_ERR),
                    rsp_data_out == '0)

endmodule

bind sequential_list_engine_unit sle_checker u_sle_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_data_out (rsp.data_out),
    .rsp_status   (rsp.status),
    .rsp_count    (rsp.count)
);

`default_nettype wire
